// ===== hdl/timer_period_split_scheduler_defines.svh =====
// ---------------------------------------------------------------------------
// Timer period split scheduler: assertion macros
// Concurrent check wrappers, compiled out when ASSERT_OFF is set.
// ---------------------------------------------------------------------------
`ifndef TIMER_PERIOD_SPLIT_SCHEDULER_DEFINES_SVH
`define TIMER_PERIOD_SPLIT_SCHEDULER_DEFINES_SVH

`ifndef ASSERT_OFF
`define TSPS_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("tsps: same-cycle check failed");
`define TSPS_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("tsps: next-cycle check failed");
`else
`define TSPS_ASSERT_IMPL(lbl, clk, rst_n, pre, post)
`define TSPS_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif

`endif

// ===== hdl/tsps_pkg.sv =====
// ---------------------------------------------------------------------------
// Timer period split scheduler package
// Widths, constants, codes and payload types shared by the scheduler.
// ---------------------------------------------------------------------------
package tsps_pkg;

    localparam int MAX_COMPARE  = 255;
    localparam int SINGLE_LIMIT = 256;
    localparam int MS_TO_US     = 1000;

    localparam int TICK_W    = 8;
    localparam int MS_W      = 22;
    localparam int TICKS_W   = 32;
    localparam int CNT_W     = 32;
    localparam int PER_OUT_W = 9;

    localparam int CMP_W     = $clog2(MAX_COMPARE + 1);
    // divisor width covers both the tick length and the largest compare value
    localparam int DIV_W     = (CMP_W > TICK_W) ? CMP_W : TICK_W;
    localparam int PER_W     = (DIV_W > PER_OUT_W) ? DIV_W : PER_OUT_W;

    localparam int MUL_STEPS = $clog2(MS_TO_US + 1);
    localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);
    localparam int DIV_CNT_W = $clog2(TICKS_W + 1);

    localparam logic FUNC_START  = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_ZERO = 1'b1;

    typedef struct packed {
        logic            func;
        logic [MS_W-1:0] time_ms;
    } tsps_in_t;

    typedef struct packed {
        logic [PER_OUT_W-1:0] period_ticks;
        logic [CNT_W-1:0]     match_count;
        logic                 fire;
        logic                 status;
    } tsps_out_t;

    typedef struct packed {
        logic               done;
        logic [TICKS_W-1:0] quotient;
        logic [DIV_W-1:0]   remainder;
    } tsps_div_res_t;

endpackage

// ===== hdl/tsps_mul.sv =====
// ---------------------------------------------------------------------------
// Millisecond to microsecond converter
// Shift-and-add multiply by the fixed microseconds-per-millisecond factor,
// one multiplier bit per cycle.
// ---------------------------------------------------------------------------
module tsps_mul (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [tsps_pkg::MS_W-1:0]     ms,
    output logic                          done,
    output logic [tsps_pkg::TICKS_W-1:0]  product
);
    import tsps_pkg::*;

    logic [TICKS_W-1:0]   mcand_reg;
    logic [MUL_STEPS-1:0] mplier_reg;
    logic [TICKS_W-1:0]   acc_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                mcand_reg  <= TICKS_W'(ms);
                mplier_reg <= MUL_STEPS'(MS_TO_US);
                acc_reg    <= '0;
                cnt_reg    <= '0;
                busy_reg   <= 1'b1;
            end else if (busy_reg) begin
                if (mplier_reg[0]) begin
                    acc_reg <= acc_reg + mcand_reg;
                end
                mcand_reg  <= {mcand_reg[TICKS_W-2:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[MUL_STEPS-1:1]};
                cnt_reg    <= cnt_reg + MUL_CNT_W'(1);
                if (cnt_reg == MUL_CNT_W'(MUL_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ===== hdl/tsps_div.sv =====
// ---------------------------------------------------------------------------
// Bit-serial divider
// Restoring division, one quotient bit per cycle; shared by the tick
// conversion and the divisor search.
// ---------------------------------------------------------------------------
module tsps_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [tsps_pkg::TICKS_W-1:0]    dividend,
    input  logic [tsps_pkg::DIV_W-1:0]      divisor,
    output tsps_pkg::tsps_div_res_t         res
);
    import tsps_pkg::*;

    logic [TICKS_W-1:0]   quo_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     dsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       diff;
    logic                 fits;

    // partial remainder stays below the divisor, so one subtract per bit
    assign trial = {rem_reg, quo_reg[TICKS_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dsr_reg  <= divisor;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
                quo_reg <= {quo_reg[TICKS_W-2:0], fits};
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(TICKS_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign res.done      = done_reg;
    assign res.quotient  = quo_reg;
    assign res.remainder = rem_reg;

endmodule

// ===== hdl/timer_period_split_scheduler.sv =====
// ---------------------------------------------------------------------------
// Timer period split scheduler
// Converts a millisecond duration into a compare period and match count,
// and counts compare-match ticks, firing each time the match count is reached.
// ---------------------------------------------------------------------------
// One item at a time. A start item runs the ms-to-us multiply, the divide
// by the tick length, and then, for more than 256 ticks, one divide for
// each candidate divisor tried downward from 255 on the shared bit-serial
// divider. The result sits in an output register, so a new item is taken
// while the previous result waits. No clearing pass follows reset.
`include "timer_period_split_scheduler_defines.svh"

module timer_period_split_scheduler (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  tsps_pkg::tsps_in_t           s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output tsps_pkg::tsps_out_t          m_data,
    input  logic                         cfg_wr_en,
    input  logic [tsps_pkg::TICK_W-1:0]  cfg_wr_data
);
    import tsps_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_TICK   = 3'd1;
    localparam logic [2:0] ST_MUL    = 3'd2;
    localparam logic [2:0] ST_TICKS  = 3'd3;
    localparam logic [2:0] ST_SEARCH = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;

    logic [2:0]           state_reg;
    logic [TICK_W-1:0]    tick_us_reg;
    logic [TICKS_W-1:0]   ticks_reg;
    logic [DIV_W-1:0]     d_reg;
    logic [PER_W-1:0]     per_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 status_reg;
    logic [CNT_W-1:0]     target_reg;
    logic [CNT_W-1:0]     counter_reg;
    logic                 armed_reg;
    logic [PER_OUT_W-1:0] period_store_reg;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    tsps_out_t            m_data_reg;

    logic                 in_accept;
    logic                 slot_free;
    logic                 mul_start;
    logic                 mul_done;
    logic [TICKS_W-1:0]   mul_product;
    logic                 div_start;
    logic [TICKS_W-1:0]   div_dividend;
    logic [DIV_W-1:0]     div_divisor;
    tsps_div_res_t        div_res;
    logic [TICK_W-1:0]    tick_eff;
    logic                 ticks_zero;
    logic                 ticks_single;
    logic                 search_hit;
    logic                 search_last;
    logic                 div_phase;

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;

    // raise on a new result, drop once the waiting item is taken
    assign m_valid_next = (((state_reg == ST_TICK) || (state_reg == ST_EMIT)) && slot_free)
                          || (m_valid_reg && !m_ready);

    assign tick_eff     = (tick_us_reg == '0) ? TICK_W'(1) : tick_us_reg;
    assign ticks_zero   = (div_res.quotient == '0);
    assign ticks_single = (div_res.quotient <= TICKS_W'(SINGLE_LIMIT));
    assign search_hit   = (div_res.remainder == '0);
    assign search_last  = (d_reg == DIV_W'(2));
    assign div_phase    = (state_reg == ST_TICKS) || (state_reg == ST_SEARCH);

    assign mul_start = in_accept && (s_data.func == FUNC_START);

    always_comb begin
        div_start    = 1'b0;
        div_dividend = ticks_reg;
        div_divisor  = d_reg - DIV_W'(1);
        case (state_reg)
            ST_MUL: begin
                div_start    = mul_done;
                div_dividend = mul_product;
                div_divisor  = DIV_W'(tick_eff);
            end
            ST_TICKS: begin
                div_start    = div_res.done && !ticks_zero && !ticks_single;
                div_dividend = div_res.quotient;
                div_divisor  = DIV_W'(MAX_COMPARE);
            end
            ST_SEARCH: begin
                div_start = div_res.done && !search_hit && !search_last;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    tsps_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .ms      (s_data.time_ms),
        .done    (mul_done),
        .product (mul_product)
    );

    tsps_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .res      (div_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            tick_us_reg      <= TICK_W'(1);
            target_reg       <= '0;
            counter_reg      <= CNT_W'(1);
            armed_reg        <= 1'b0;
            period_store_reg <= '0;
            m_valid_reg      <= 1'b0;
            d_reg            <= DIV_W'(MAX_COMPARE);
        end else begin
            if (cfg_wr_en) begin
                tick_us_reg <= cfg_wr_data;
            end
            m_valid_reg <= m_valid_next;

            case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        state_reg <= (s_data.func == FUNC_TICK) ? ST_TICK : ST_MUL;
                    end
                end
                ST_TICK: begin
                    if (slot_free) begin
                        m_data_reg.fire <= armed_reg && (counter_reg == target_reg);
                        if (armed_reg) begin
                            if (counter_reg == target_reg) begin
                                counter_reg <= CNT_W'(1);
                            end else begin
                                counter_reg <= counter_reg + CNT_W'(1);
                            end
                        end
                        m_data_reg.period_ticks <= period_store_reg;
                        m_data_reg.match_count  <= target_reg;
                        m_data_reg.status       <= STATUS_OK;
                        state_reg               <= ST_IDLE;
                    end
                end
                ST_MUL: begin
                    if (mul_done) begin
                        state_reg <= ST_TICKS;
                    end
                end
                ST_TICKS: begin
                    if (div_res.done) begin
                        ticks_reg <= div_res.quotient;
                        if (ticks_zero) begin
                            per_reg    <= '0;
                            cnt_reg    <= '0;
                            status_reg <= STATUS_ZERO;
                            state_reg  <= ST_EMIT;
                        end else if (ticks_single) begin
                            per_reg    <= PER_W'(div_res.quotient[PER_OUT_W-1:0]);
                            cnt_reg    <= CNT_W'(1);
                            status_reg <= STATUS_OK;
                            state_reg  <= ST_EMIT;
                        end else begin
                            d_reg     <= DIV_W'(MAX_COMPARE);
                            state_reg <= ST_SEARCH;
                        end
                    end
                end
                ST_SEARCH: begin
                    if (div_res.done) begin
                        status_reg <= STATUS_OK;
                        if (search_hit) begin
                            per_reg   <= PER_W'(d_reg);
                            cnt_reg   <= div_res.quotient;
                            state_reg <= ST_EMIT;
                        end else if (search_last) begin
                            // no divisor above one: one tick per period
                            per_reg   <= PER_W'(1);
                            cnt_reg   <= ticks_reg;
                            state_reg <= ST_EMIT;
                        end else begin
                            d_reg <= d_reg - DIV_W'(1);
                        end
                    end
                end
                ST_EMIT: begin
                    if (slot_free) begin
                        m_data_reg.period_ticks <= per_reg[PER_OUT_W-1:0];
                        m_data_reg.match_count  <= cnt_reg;
                        m_data_reg.fire         <= 1'b0;
                        m_data_reg.status       <= status_reg;
                        if (status_reg == STATUS_OK) begin
                            period_store_reg <= per_reg[PER_OUT_W-1:0];
                            target_reg       <= cnt_reg;
                            counter_reg      <= CNT_W'(1);
                            armed_reg        <= 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `TSPS_ASSERT_IMPL(a_idle_counter, aclk, aresetn, !armed_reg, counter_reg == CNT_W'(1))
    `TSPS_ASSERT_IMPL(a_armed_target, aclk, aresetn, armed_reg, target_reg != '0)
    `TSPS_ASSERT_IMPL(a_armed_range, aclk, aresetn, armed_reg, counter_reg <= target_reg)
    `TSPS_ASSERT_IMPL(a_div_owner, aclk, aresetn, div_res.done, div_phase)
    `TSPS_ASSERT_IMPL(a_search_floor, aclk, aresetn, state_reg == ST_SEARCH, d_reg >= DIV_W'(2))
    `TSPS_ASSERT_NEXT(a_mul_to_div, aclk, aresetn, mul_done, state_reg == ST_TICKS)

endmodule
